// ----- rtl/fpd_pkg.sv -----
package fpd_pkg;

  // Phase encoding shared by the classifier and the top level.
  typedef enum logic [2:0] {
    PH_UNKNOWN   = 3'd0,
    PH_PREFLIGHT = 3'd1,
    PH_TAKEOFF   = 3'd2,
    PH_CLIMB     = 3'd3,
    PH_CRUISE    = 3'd4,
    PH_DESCENT   = 3'd5,
    PH_APPROACH  = 3'd6,
    PH_LANDING   = 3'd7
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IDLE_THR      = 3'd0,
    REG_LAND_THR      = 3'd1,
    REG_TAKEOFF_SPD   = 3'd2,
    REG_CRUISE_SPD    = 3'd3,
    REG_LAND_SPD      = 3'd4,
    REG_CLIMB_VR      = 3'd5,
    REG_DESCENT_VR    = 3'd6,
    REG_HOLD_TIME_MS  = 3'd7
  } cfg_reg_t;

  localparam int unsigned ThrW  = 13;
  localparam int unsigned SpdW  = 16;
  localparam int unsigned RateW = 16;
  localparam int unsigned HoldW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  // Reset values of the thresholds.
  localparam logic [ThrW-1:0]         PreflightThrottleRst = 13'd205;
  localparam logic [ThrW-1:0]         LandingThrottleRst   = 13'd614;
  localparam logic [SpdW-1:0]         TakeoffAirspeedRst   = 16'd768;
  localparam logic [SpdW-1:0]         CruiseAirspeedRst    = 16'd3072;
  localparam logic [SpdW-1:0]         LandingAirspeedRst   = 16'd2048;
  localparam logic signed [RateW-1:0] ClimbRateRst         = 16'sd128;
  localparam logic signed [RateW-1:0] DescentRateRst       = -16'sd64;
  localparam logic [HoldW-1:0]        HoldTimeRst          = 16'd500;

  // All thresholds as one bundle.
  typedef struct packed {
    logic [ThrW-1:0]         idle_thr_max;
    logic [ThrW-1:0]         land_thr_max;
    logic [SpdW-1:0]         takeoff_spd_min;
    logic [SpdW-1:0]         cruise_spd_min;
    logic [SpdW-1:0]         land_spd_max;
    logic signed [RateW-1:0] climb_vr_min;
    logic signed [RateW-1:0] descent_vr_max;
    logic [HoldW-1:0]        hold_time_ms;
  } cfg_t;

endpackage

// ----- rtl/fpd_cfg_regs.sv -----
module fpd_cfg_regs
  import fpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output cfg_t            cfg
);

  // Threshold registers, written one at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_thr_max    <= PreflightThrottleRst;
      cfg.land_thr_max    <= LandingThrottleRst;
      cfg.takeoff_spd_min <= TakeoffAirspeedRst;
      cfg.cruise_spd_min  <= CruiseAirspeedRst;
      cfg.land_spd_max    <= LandingAirspeedRst;
      cfg.climb_vr_min    <= ClimbRateRst;
      cfg.descent_vr_max  <= DescentRateRst;
      cfg.hold_time_ms    <= HoldTimeRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IDLE_THR:     cfg.idle_thr_max    <= cfg_data[ThrW-1:0];
        REG_LAND_THR:     cfg.land_thr_max    <= cfg_data[ThrW-1:0];
        REG_TAKEOFF_SPD:  cfg.takeoff_spd_min <= cfg_data[SpdW-1:0];
        REG_CRUISE_SPD:   cfg.cruise_spd_min  <= cfg_data[SpdW-1:0];
        REG_LAND_SPD:     cfg.land_spd_max    <= cfg_data[SpdW-1:0];
        REG_CLIMB_VR:     cfg.climb_vr_min    <= signed'(cfg_data[RateW-1:0]);
        REG_DESCENT_VR:   cfg.descent_vr_max  <= signed'(cfg_data[RateW-1:0]);
        REG_HOLD_TIME_MS: cfg.hold_time_ms    <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/fpd_classify.sv -----
module fpd_classify
  import fpd_pkg::*;
(
  input  cfg_t                    cfg,
  input  phase_t                  committed,
  input  logic [ThrW-1:0]         throttle,
  input  logic [SpdW-1:0]         airspeed,
  input  logic signed [RateW-1:0] nose_rate,
  output phase_t                  cand
);

  logic thr_gt_pre;
  logic thr_lt_pre;
  logic thr_gt_land;
  logic thr_lt_land;
  logic spd_gt_to;
  logic spd_lt_to;
  logic spd_gt_cruise;
  logic spd_lt_land;
  logic vr_gt_climb;
  logic vr_lt_climb;
  logic vr_lt_desc;
  logic vr_pos;

  // Threshold comparisons, each computed once.
  assign thr_gt_pre    = throttle > cfg.idle_thr_max;
  assign thr_lt_pre    = throttle < cfg.idle_thr_max;
  assign thr_gt_land   = throttle > cfg.land_thr_max;
  assign thr_lt_land   = throttle < cfg.land_thr_max;
  assign spd_gt_to     = airspeed > cfg.takeoff_spd_min;
  assign spd_lt_to     = airspeed < cfg.takeoff_spd_min;
  assign spd_gt_cruise = airspeed > cfg.cruise_spd_min;
  assign spd_lt_land   = airspeed < cfg.land_spd_max;
  assign vr_gt_climb   = nose_rate > $signed(cfg.climb_vr_min);
  assign vr_lt_climb   = nose_rate < $signed(cfg.climb_vr_min);
  assign vr_lt_desc    = nose_rate < $signed(cfg.descent_vr_max);
  assign vr_pos        = nose_rate > 16'sd0;

  // Transition rules, selected by the committed phase; unknown acts as preflight.
  always_comb begin
    cand = committed;
    unique case (committed)
      PH_UNKNOWN, PH_PREFLIGHT: begin
        cand = (thr_gt_pre && spd_gt_to) ? PH_TAKEOFF : PH_PREFLIGHT;
      end
      PH_TAKEOFF: begin
        if (spd_gt_cruise && vr_lt_climb) cand = PH_CRUISE;
        else if (vr_gt_climb)             cand = PH_CLIMB;
        else                              cand = PH_TAKEOFF;
      end
      PH_CLIMB: begin
        if (vr_lt_climb && spd_gt_cruise)    cand = PH_CRUISE;
        else if (thr_lt_land && vr_lt_desc)  cand = PH_DESCENT;
        else                                 cand = PH_CLIMB;
      end
      PH_CRUISE: begin
        if (vr_gt_climb)                     cand = PH_CLIMB;
        else if (thr_lt_land && vr_lt_desc)  cand = PH_DESCENT;
        else                                 cand = PH_CRUISE;
      end
      PH_DESCENT: begin
        if (spd_lt_land && thr_lt_land) cand = PH_APPROACH;
        else if (vr_gt_climb)           cand = PH_CLIMB;
        else                            cand = PH_DESCENT;
      end
      PH_APPROACH: begin
        if (spd_lt_to && thr_lt_pre)    cand = PH_LANDING;
        else if (thr_gt_land || vr_pos) cand = PH_CLIMB;
        else                            cand = PH_APPROACH;
      end
      PH_LANDING: begin
        if (spd_lt_to && thr_lt_pre) cand = PH_PREFLIGHT;
        else if (thr_gt_pre)         cand = PH_TAKEOFF;
        else                         cand = PH_LANDING;
      end
      default: cand = committed;
    endcase
  end

endmodule

// ----- rtl/flight_phase_detector_unit.sv -----
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------
// sample in | in_valid / in_ready  | throttle, airspeed, nose_rate, now_ms
// result    | out_valid / out_ready| phase, pending, phase_changed
// config    | cfg_we               | cfg_index, cfg_data
//
// One request is accepted per cycle; its result is valid on the next cycle.
// The phase state and the result register update in the cycle of acceptance,
// so the throughput is set by the single classify/hold-compare path.
// A stalled result holds its register; in_ready is low only while a result
// waits and out_ready is low. Synchronous active-high reset restores all
// thresholds and clears the phase state to unknown with no result pending.
module flight_phase_detector_unit
  import fpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ThrW-1:0]         throttle,
  input  logic [SpdW-1:0]         airspeed,
  input  logic signed [RateW-1:0] nose_rate,
  input  logic [TimeW-1:0]        now_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              phase,
  output logic [2:0]              pending,
  output logic                    phase_changed,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CfgW-1:0]         cfg_data
);

  cfg_t             cfg;
  phase_t           cand;
  phase_t           committed;
  phase_t           committed_next;
  phase_t           pend;
  phase_t           pend_next;
  logic [TimeW-1:0] since;
  logic [TimeW-1:0] since_next;
  logic [TimeW-1:0] elapsed;
  logic             changed;
  logic             changed_next;
  logic             accept;

  fpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpd_classify u_classify (
    .cfg        (cfg),
    .committed  (committed),
    .throttle   (throttle),
    .airspeed   (airspeed),
    .nose_rate  (nose_rate),
    .cand       (cand)
  );

  // A new request is taken whenever the result register is empty or draining.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Pending tracking and hold-time commit, with wrapping elapsed time.
  assign elapsed = now_ms - since;

  always_comb begin
    committed_next = committed;
    pend_next      = pend;
    since_next     = since;
    changed_next   = 1'b0;
    if (cand != committed) begin
      if (cand != pend) begin
        pend_next  = cand;
        since_next = now_ms;
      end else if (elapsed > {{(TimeW-HoldW){1'b0}}, cfg.hold_time_ms}) begin
        committed_next = cand;
        changed_next   = 1'b1;
      end
    end else begin
      pend_next = committed;
    end
  end

  // Phase state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= PH_UNKNOWN;
      pend      <= PH_UNKNOWN;
      since     <= '0;
      changed   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        committed <= committed_next;
        pend      <= pend_next;
        since     <= since_next;
        changed   <= changed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign phase         = committed;
  assign pending       = pend;
  assign phase_changed = changed;

  // The result register must be empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A commit always lands on the phase that was pending.
  a_commit_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase_changed) |-> (phase == pending))
    else $error("committed phase differs from pending");

  // Phase state moves only when a request is accepted.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(committed) && $stable(pend) && $stable(since)))
    else $error("phase state changed without a request");

  // A result waiting on a stalled consumer is neither lost nor overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(changed)))
    else $error("stalled result dropped or overwritten");

endmodule

// ----- tb/tb_flight_phase_detector_unit.sv -----
module tb_flight_phase_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    phase_t phase;
    phase_t pending;
    logic   changed;
  } phase_report_t;

  // One row of the directed flight script. Rows with typed set carry a
  // hand-written result; the others are checked against the phase tracker.
  typedef struct packed {
    logic [ThrW-1:0]         thr;
    logic [SpdW-1:0]         spd;
    logic signed [RateW-1:0] rate;
    logic [TimeW-1:0]        stamp;
    logic                    typed;
    phase_report_t           want;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ThrW-1:0]         throttle = '0;
  logic [SpdW-1:0]         airspeed = '0;
  logic signed [RateW-1:0] nose_rate = '0;
  logic [TimeW-1:0]        now_ms = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              phase;
  logic [2:0]              pending;
  logic                    phase_changed;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [CfgW-1:0]         cfg_data = '0;

  // Side data that travels with the request on the input channel.
  logic          row_typed = 1'b0;
  phase_report_t row_want = '0;

  // Mirror of the thresholds as last written.
  logic [ThrW-1:0]         lim_preflight_thr = PreflightThrottleRst;
  logic [ThrW-1:0]         lim_landing_thr   = LandingThrottleRst;
  logic [SpdW-1:0]         lim_takeoff_spd   = TakeoffAirspeedRst;
  logic [SpdW-1:0]         lim_cruise_spd    = CruiseAirspeedRst;
  logic [SpdW-1:0]         lim_landing_spd   = LandingAirspeedRst;
  logic signed [RateW-1:0] lim_climb_rate    = ClimbRateRst;
  logic signed [RateW-1:0] lim_descent_rate  = DescentRateRst;
  logic [HoldW-1:0]        hold_ms           = HoldTimeRst;

  // Phase tracking state of the predictor.
  phase_t           committed = PH_UNKNOWN;
  phase_t           awaiting = PH_UNKNOWN;
  logic [TimeW-1:0] awaiting_since = '0;

  phase_report_t    reports_due[$];
  script_row_t      flight_script[$];
  logic [TimeW-1:0] flight_clock_ms = '0;

  int  mismatches = 0;
  int  samples_sent = 0;
  int  commits_seen = 0;
  int  settings_run = 1;
  bit  steady = 1'b0;
  bit  flood = 1'b0;
  bit  hold_off_req = 1'b0;

  flight_phase_detector_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .throttle     (throttle),
    .airspeed     (airspeed),
    .nose_rate    (nose_rate),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phase        (phase),
    .pending      (pending),
    .phase_changed(phase_changed),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Candidate phase from the threshold rules of the committed phase.
  function automatic phase_t classify_sample(input logic [ThrW-1:0] thr,
                                             input logic [SpdW-1:0] spd,
                                             input logic signed [RateW-1:0] rate);
    case (committed)
      PH_UNKNOWN, PH_PREFLIGHT: begin
        if (thr > lim_preflight_thr && spd > lim_takeoff_spd) return PH_TAKEOFF;
        return PH_PREFLIGHT;
      end
      PH_TAKEOFF: begin
        if (spd > lim_cruise_spd && rate < lim_climb_rate) return PH_CRUISE;
        if (rate > lim_climb_rate) return PH_CLIMB;
        return PH_TAKEOFF;
      end
      PH_CLIMB: begin
        if (rate < lim_climb_rate && spd > lim_cruise_spd) return PH_CRUISE;
        if (thr < lim_landing_thr && rate < lim_descent_rate) return PH_DESCENT;
        return PH_CLIMB;
      end
      PH_CRUISE: begin
        if (rate > lim_climb_rate) return PH_CLIMB;
        if (thr < lim_landing_thr && rate < lim_descent_rate) return PH_DESCENT;
        return PH_CRUISE;
      end
      PH_DESCENT: begin
        if (spd < lim_landing_spd && thr < lim_landing_thr) return PH_APPROACH;
        if (rate > lim_climb_rate) return PH_CLIMB;
        return PH_DESCENT;
      end
      PH_APPROACH: begin
        if (spd < lim_takeoff_spd && thr < lim_preflight_thr) return PH_LANDING;
        if (thr > lim_landing_thr || rate > 16'sd0) return PH_CLIMB;
        return PH_APPROACH;
      end
      default: begin
        if (spd < lim_takeoff_spd && thr < lim_preflight_thr) return PH_PREFLIGHT;
        if (thr > lim_preflight_thr) return PH_TAKEOFF;
        return PH_LANDING;
      end
    endcase
  endfunction

  // Advances the phase state by one sample and returns the result it gives.
  function automatic phase_report_t track_phase(input logic [ThrW-1:0] thr,
                                                input logic [SpdW-1:0] spd,
                                                input logic signed [RateW-1:0] rate,
                                                input logic [TimeW-1:0] stamp);
    phase_t           guess;
    logic [TimeW-1:0] held;
    phase_report_t    rep;
    guess = classify_sample(thr, spd, rate);
    held = stamp - awaiting_since;
    rep.changed = 1'b0;
    if (guess != committed) begin
      if (guess != awaiting) begin
        awaiting = guess;
        awaiting_since = stamp;
      end else if (held > TimeW'(hold_ms)) begin
        committed = guess;
        rep.changed = 1'b1;
      end
    end else begin
      awaiting = committed;
    end
    rep.phase = committed;
    rep.pending = awaiting;
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Result check first, then the prediction for a newly accepted request.
  // The result of a request shows up in the cycle after its acceptance at the earliest.
  always @(posedge clk) begin
    phase_report_t want;
    phase_report_t rep;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with no request outstanding: phase %0d pending %0d",
                   $time, phase, pending);
        end else begin
          want = reports_due.pop_front();
          check_field("phase", want.phase, phase);
          check_field("pending", want.pending, pending);
          check_field("phase_changed", {2'b00, want.changed}, {2'b00, phase_changed});
        end
        if (phase_changed === 1'b1) commits_seen++;
      end
      if (in_valid && in_ready) begin
        rep = track_phase(throttle, airspeed, nose_rate, now_ms);
        if (row_typed) rep = row_want;
        reports_due.push_back(rep);
      end
    end
  end

  // Result side: a random stall before each result, or a long hold-off on
  // request so that the block fills and pushes back on its input.
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_off_req) begin
        stall = 60;
        hold_off_req = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one request after a random gap (none in steady or flood mode) and returns once it is accepted.
  task automatic offer_sample(input logic [ThrW-1:0] thr, input logic [SpdW-1:0] spd,
                              input logic signed [RateW-1:0] rate,
                              input logic [TimeW-1:0] stamp,
                              input logic typed, input phase_report_t want);
    int gap;
    gap = (steady || flood) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    throttle = thr;
    airspeed = spd;
    nose_rate = rate;
    now_ms = stamp;
    row_typed = typed;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Stops offering and waits until every outstanding result is back.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_threshold(input cfg_reg_t idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_IDLE_THR:    lim_preflight_thr = val[ThrW-1:0];
      REG_LAND_THR:    lim_landing_thr = val[ThrW-1:0];
      REG_TAKEOFF_SPD: lim_takeoff_spd = val;
      REG_CRUISE_SPD:  lim_cruise_spd = val;
      REG_LAND_SPD:    lim_landing_spd = val;
      REG_CLIMB_VR:    lim_climb_rate = val;
      REG_DESCENT_VR:  lim_descent_rate = val;
      default:         hold_ms = val;
    endcase
  endtask

  task automatic program_limits(input logic [CfgW-1:0] pre_thr, input logic [CfgW-1:0] land_thr,
                                input logic [CfgW-1:0] to_spd, input logic [CfgW-1:0] cr_spd,
                                input logic [CfgW-1:0] land_spd, input logic [CfgW-1:0] climb,
                                input logic [CfgW-1:0] descent, input logic [CfgW-1:0] hold);
    settle();
    write_threshold(REG_HOLD_TIME_MS, hold);
    write_threshold(REG_IDLE_THR, pre_thr);
    write_threshold(REG_LAND_THR, land_thr);
    write_threshold(REG_TAKEOFF_SPD, to_spd);
    write_threshold(REG_CRUISE_SPD, cr_spd);
    write_threshold(REG_LAND_SPD, land_spd);
    write_threshold(REG_CLIMB_VR, climb);
    write_threshold(REG_DESCENT_VR, descent);
    flight_clock_ms = $urandom;
    settings_run++;
  endtask

  // Field values cluster around the current thresholds, where the rules flip.
  function automatic logic [ThrW-1:0] pick_throttle();
    logic [ThrW-1:0] nudge;
    nudge = ThrW'($urandom_range(0, 2)) - 1'b1;
    case ($urandom_range(0, 5))
      0:       return lim_preflight_thr + nudge;
      1:       return lim_landing_thr + nudge;
      2:       return '0;
      3:       return 13'd4096;
      4:       return ThrW'($urandom_range(0, 4096));
      default: return ThrW'($urandom);
    endcase
  endfunction

  function automatic logic [SpdW-1:0] pick_airspeed();
    logic [SpdW-1:0] nudge;
    nudge = SpdW'($urandom_range(0, 2)) - 1'b1;
    case ($urandom_range(0, 5))
      0:       return lim_takeoff_spd + nudge;
      1:       return lim_cruise_spd + nudge;
      2:       return lim_landing_spd + nudge;
      3:       return '0;
      4:       return '1;
      default: return SpdW'($urandom);
    endcase
  endfunction

  function automatic logic signed [RateW-1:0] pick_rate();
    logic signed [RateW-1:0] nudge;
    nudge = RateW'($urandom_range(0, 2)) - 1'b1;
    case ($urandom_range(0, 5))
      0:       return lim_climb_rate + nudge;
      1:       return lim_descent_rate + nudge;
      2:       return nudge;
      3:       return 16'sh8000;
      4:       return 16'sh7fff;
      default: return RateW'($urandom);
    endcase
  endfunction

  // Mostly bursts of one repeated sample with advancing time, so candidates
  // persist long enough to commit; the rest is unrelated noise.
  task automatic fly_random(input int count);
    int                      left;
    int                      reps;
    logic [ThrW-1:0]         thr;
    logic [SpdW-1:0]         spd;
    logic signed [RateW-1:0] rate;
    logic [TimeW-1:0]        advance_ms;
    left = count;
    while (left > 0) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 15) begin
        offer_sample(ThrW'($urandom), SpdW'($urandom), RateW'($urandom), $urandom,
                     1'b0, '0);
        left--;
      end else begin
        thr = pick_throttle();
        spd = pick_airspeed();
        rate = pick_rate();
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          case ($urandom_range(0, 9))
            0:       advance_ms = $urandom;
            1:       advance_ms = TimeW'(hold_ms);
            2:       advance_ms = TimeW'(hold_ms) + 1'b1;
            default: advance_ms = $urandom_range(0, int'(hold_ms) / 2 + 1);
          endcase
          flight_clock_ms += advance_ms;
          offer_sample(thr, spd, rate, flight_clock_ms, 1'b0, '0);
          left--;
        end
      end
    end
    steady = 1'b0;
  endtask

  function automatic void add_row(input int thr, input int spd, input int rate,
                                  input logic [TimeW-1:0] stamp, input logic typed,
                                  input phase_t ph, input phase_t pd, input logic ch);
    script_row_t row;
    row.thr = ThrW'(thr);
    row.spd = SpdW'(spd);
    row.rate = RateW'(rate);
    row.stamp = stamp;
    row.typed = typed;
    row.want.phase = ph;
    row.want.pending = pd;
    row.want.changed = ch;
    flight_script.push_back(row);
  endfunction

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A full flight under the reset thresholds: hold boundary, out-of-range
    // throttle, timestamp wrap, backwards time, and candidates that fall back.
    add_row(0, 0, 0, 0, 1, PH_UNKNOWN, PH_PREFLIGHT, 0);
    add_row(0, 0, 0, 500, 1, PH_UNKNOWN, PH_PREFLIGHT, 0);
    add_row(0, 0, 0, 501, 1, PH_PREFLIGHT, PH_PREFLIGHT, 1);
    add_row(8191, 65535, 0, 1000, 1, PH_PREFLIGHT, PH_TAKEOFF, 0);
    add_row(206, 769, 0, 1501, 1, PH_TAKEOFF, PH_TAKEOFF, 1);
    add_row(0, 0, 32767, 32'hffff_ff00, 1, PH_TAKEOFF, PH_CLIMB, 0);
    add_row(0, 0, 129, 32'h0000_0200, 1, PH_CLIMB, PH_CLIMB, 1);
    add_row(0, 3073, -32768, 1000, 1, PH_CLIMB, PH_CRUISE, 0);
    add_row(4096, 0, 128, 1050, 0, PH_UNKNOWN, PH_UNKNOWN, 0);
    add_row(0, 3073, -32768, 1100, 0, PH_UNKNOWN, PH_UNKNOWN, 0);
    add_row(0, 3073, -32768, 50, 1, PH_CRUISE, PH_CRUISE, 1);
    add_row(0, 0, -65, 2000, 1, PH_CRUISE, PH_DESCENT, 0);
    add_row(0, 0, -65, 2501, 1, PH_DESCENT, PH_DESCENT, 1);
    add_row(613, 2047, 0, 3000, 1, PH_DESCENT, PH_APPROACH, 0);
    add_row(613, 2047, 0, 3501, 1, PH_APPROACH, PH_APPROACH, 1);
    add_row(204, 767, 0, 4000, 1, PH_APPROACH, PH_LANDING, 0);
    add_row(204, 767, 0, 4501, 1, PH_LANDING, PH_LANDING, 1);
    add_row(206, 0, 0, 5000, 1, PH_LANDING, PH_TAKEOFF, 0);
    add_row(0, 0, 0, 5001, 0, PH_UNKNOWN, PH_UNKNOWN, 0);
    add_row(205, 0, 0, 5100, 0, PH_UNKNOWN, PH_UNKNOWN, 0);
    add_row(0, 0, 0, 6000, 0, PH_UNKNOWN, PH_UNKNOWN, 0);
    add_row(0, 0, 0, 6501, 1, PH_PREFLIGHT, PH_PREFLIGHT, 1);
    foreach (flight_script[i]) begin
      offer_sample(flight_script[i].thr, flight_script[i].spd, flight_script[i].rate,
                   flight_script[i].stamp, flight_script[i].typed, flight_script[i].want);
    end

    flight_clock_ms = 32'd7000;
    fly_random(300);

    // Back-pressure: the sink holds off while requests keep coming, then the
    // source waits for every result before going on.
    hold_off_req = 1'b1;
    flood = 1'b1;
    fly_random(40);
    flood = 1'b0;
    settle();
    fly_random(100);

    // Every threshold at zero, with no hold time at all.
    program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000);
    fly_random(300);

    // Every threshold at its top but the descent rate at its bottom; throttle limits take only their low bits.
    program_limits(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff,
                   16'h8000, 16'hffff);
    fly_random(300);

    // Rate limits swapped to the opposite extremes and a one-millisecond hold.
    program_limits(16'd4096, 16'd4096, 16'h0100, 16'h8000, 16'h4000, 16'h8000,
                   16'h7fff, 16'd1);
    fly_random(300);

    program_limits(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                   CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                   CfgW'($urandom_range(0, 2000)));
    fly_random(300);

    program_limits(16'(PreflightThrottleRst), 16'(LandingThrottleRst), TakeoffAirspeedRst,
                   CruiseAirspeedRst, LandingAirspeedRst, ClimbRateRst, DescentRateRst,
                   HoldTimeRst);
    fly_random(300);

    settle();
    repeat (4) @(negedge clk);
    $display("Flew %0d samples through %0d threshold settings; %0d phase commits seen.",
             samples_sent, settings_run, commits_seen);
    $display("Stalls on both sides, a long sink hold-off and timestamp wraps included.");
    if (mismatches == 0) begin
      $display("flight_phase_detector_unit: match");
    end else begin
      $display("flight_phase_detector_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("flight_phase_detector_unit: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fpd_pkg.sv
rtl/fpd_cfg_regs.sv
rtl/fpd_classify.sv
rtl/flight_phase_detector_unit.sv
tb/tb_flight_phase_detector_unit.sv
